### sv/mppt_ic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_ic_pkg
// Types, constants and the microcode table of the MPPT tracker.
// ----------------------------------------------------------------------------
package mppt_ic_pkg;

  // Field and datapath widths
  localparam int V_W       = 15;  // voltage / current sample
  localparam int DUTY_W    = 8;
  localparam int TOL_W     = 10;
  localparam int CFG_W     = 15;  // widest register
  localparam int CFG_IDX_W = 3;
  localparam int NUM_W     = 25;  // |x| * 1000 for a 15-bit x
  localparam int DEN_W     = 15;
  localparam int DIFF_W    = 27;  // inc - inst, signed
  localparam int D_W       = 10;  // duty before clamp, signed
  localparam int SCALE     = 1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_V     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK  = 3'd5;

  // Reset values
  localparam logic [DUTY_W-1:0] RST_DUTY_MIN  = 8'd10;
  localparam logic [DUTY_W-1:0] RST_DUTY_MAX  = 8'd150;
  localparam logic [DUTY_W-1:0] RST_DUTY_STEP = 8'd5;
  localparam logic [TOL_W-1:0]  RST_TOLERANCE = 10'd10;
  localparam logic [V_W-1:0]    RST_MIN_V     = 15'd1000;
  localparam logic [DUTY_W-1:0] RST_FALLBACK  = 8'd20;
  localparam logic [DUTY_W-1:0] RST_DUTY_NOW  = 8'd80;

  // Microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_DIFF, OP_MUL, OP_DIVGO, OP_WAIT, OP_SUB,
    OP_DECIDE, OP_FLAT, OP_CLAMP, OP_EMIT, OP_FALLBK
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER, C_NOSTART, C_LOWV, C_FLAT, C_DIVBUSY, C_OUTBUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;  // taken when cond holds
    step_t tgt_f;  // taken otherwise
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic low_v;
    logic flat;
    logic div_busy;
    logic out_busy;
  } flags_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_DIFF   = 4'd1;
  localparam step_t S_MUL    = 4'd2;
  localparam step_t S_DIVGO  = 4'd3;
  localparam step_t S_WAIT   = 4'd4;
  localparam step_t S_SUB    = 4'd5;
  localparam step_t S_DECIDE = 4'd6;
  localparam step_t S_FLAT   = 4'd7;
  localparam step_t S_CLAMP  = 4'd8;
  localparam step_t S_EMIT   = 4'd9;
  localparam step_t S_FALLBK = 4'd10;

  function automatic ctrl_t rom_word(input step_t s);
    ctrl_t w;
    case (s)
      S_IDLE:   w = '{op: OP_IDLE,   cond: C_NOSTART, tgt_t: S_IDLE,   tgt_f: S_DIFF};
      S_DIFF:   w = '{op: OP_DIFF,   cond: C_LOWV,    tgt_t: S_FALLBK, tgt_f: S_MUL};
      S_MUL:    w = '{op: OP_MUL,    cond: C_FLAT,    tgt_t: S_FLAT,   tgt_f: S_DIVGO};
      S_DIVGO:  w = '{op: OP_DIVGO,  cond: C_NEVER,   tgt_t: S_WAIT,   tgt_f: S_WAIT};
      S_WAIT:   w = '{op: OP_WAIT,   cond: C_DIVBUSY, tgt_t: S_WAIT,   tgt_f: S_SUB};
      S_SUB:    w = '{op: OP_SUB,    cond: C_NEVER,   tgt_t: S_DECIDE, tgt_f: S_DECIDE};
      S_DECIDE: w = '{op: OP_DECIDE, cond: C_NEVER,   tgt_t: S_CLAMP,  tgt_f: S_CLAMP};
      S_FLAT:   w = '{op: OP_FLAT,   cond: C_NEVER,   tgt_t: S_CLAMP,  tgt_f: S_CLAMP};
      S_CLAMP:  w = '{op: OP_CLAMP,  cond: C_NEVER,   tgt_t: S_EMIT,   tgt_f: S_EMIT};
      S_EMIT:   w = '{op: OP_EMIT,   cond: C_OUTBUSY, tgt_t: S_EMIT,   tgt_f: S_IDLE};
      S_FALLBK: w = '{op: OP_FALLBK, cond: C_NEVER,   tgt_t: S_EMIT,   tgt_f: S_EMIT};
      default:  w = '{op: OP_IDLE,   cond: C_NEVER,   tgt_t: S_IDLE,   tgt_f: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### sv/mppt_ic_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_ic_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mppt_ic_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mppt_ic_pkg::NUM_W-1:0] dividend,
  input  logic [mppt_ic_pkg::DEN_W-1:0] divisor,
  output logic [mppt_ic_pkg::NUM_W-1:0] quotient,
  output logic                          busy
);

  localparam int CNT_W = $clog2(mppt_ic_pkg::NUM_W);

  logic [mppt_ic_pkg::DEN_W-1:0] den;
  logic [mppt_ic_pkg::DEN_W-1:0] rem;
  logic [CNT_W-1:0]              cnt;
  logic [mppt_ic_pkg::DEN_W:0]   trial;
  logic                          fits;

  assign trial = {rem, quotient[mppt_ic_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(mppt_ic_pkg::NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      // shift the next dividend bit into the remainder, quotient bit in at the bottom
      rem      <= fits ? mppt_ic_pkg::DEN_W'(trial - {1'b0, den})
                       : trial[mppt_ic_pkg::DEN_W-1:0];
      quotient <= {quotient[mppt_ic_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

### sv/mppt_ic_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_ic_seq
// Step counter and microcode table; each word jumps on one condition.
// ----------------------------------------------------------------------------
module mppt_ic_seq (
  input  logic                clk,
  input  logic                rst,
  input  mppt_ic_pkg::flags_t flags,
  output mppt_ic_pkg::op_t    op
);

  mppt_ic_pkg::step_t step;
  mppt_ic_pkg::step_t step_next;
  mppt_ic_pkg::ctrl_t word;
  logic               hit;

  assign word = mppt_ic_pkg::rom_word(step);
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      mppt_ic_pkg::C_NEVER:   hit = 1'b0;
      mppt_ic_pkg::C_NOSTART: hit = !flags.start;
      mppt_ic_pkg::C_LOWV:    hit = flags.low_v;
      mppt_ic_pkg::C_FLAT:    hit = flags.flat;
      mppt_ic_pkg::C_DIVBUSY: hit = flags.div_busy;
      mppt_ic_pkg::C_OUTBUSY: hit = flags.out_busy;
      default:                hit = 1'b0;
    endcase
    step_next = hit ? word.tgt_t : word.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mppt_ic_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

### sv/mppt_incremental_conductance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_incremental_conductance_top
// Solar MPPT step: incremental conductance with a perturb-and-observe flat
// zone. One sample in, one new duty out.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------
//  in      | voltage_mv[14:0] current_ma[14:0]         | in_valid / in_stall
//  out     | duty[7:0] at_peak low_voltage             | out_valid / out_stall
//  cfg     | cfg_index[2:0] cfg_data[14:0]             | cfg_we, no wait
//
//  Conductance path: the two 25-bit radix-2 dividers run side by side and
//  are waited on in S_WAIT. Flat zone and low voltage skip the dividers.
//  Flat zone goes through S_FLAT; low voltage through S_FALLBK, no clamp.
//  A sample is taken only while the sequencer sits at its idle step; a result
//  held in the output register does not block the next sample, only the emit
//  step of that sample.
//  rst is synchronous: config to defaults, duty_now 80, previous sample 0.
//
module mppt_incremental_conductance_top (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mppt_ic_pkg::V_W-1:0]       voltage_mv,
  input  logic [mppt_ic_pkg::V_W-1:0]       current_ma,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mppt_ic_pkg::DUTY_W-1:0]    duty,
  output logic                              at_peak,
  output logic                              low_voltage,
  // configuration
  input  logic                              cfg_we,
  input  logic [mppt_ic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mppt_ic_pkg::CFG_W-1:0]     cfg_data
);

  localparam int V_W    = mppt_ic_pkg::V_W;
  localparam int DUTY_W = mppt_ic_pkg::DUTY_W;
  localparam int TOL_W  = mppt_ic_pkg::TOL_W;
  localparam int NUM_W  = mppt_ic_pkg::NUM_W;
  localparam int DIFF_W = mppt_ic_pkg::DIFF_W;
  localparam int D_W    = mppt_ic_pkg::D_W;

  // configuration registers
  logic [DUTY_W-1:0] duty_min;
  logic [DUTY_W-1:0] duty_max;
  logic [DUTY_W-1:0] duty_step;
  logic [TOL_W-1:0]  tolerance;
  logic [V_W-1:0]    min_voltage_mv;
  logic [DUTY_W-1:0] fallback_duty;

  // tracker state
  logic [DUTY_W-1:0] duty_now;
  logic [V_W-1:0]    prev_voltage;
  logic [V_W-1:0]    prev_current;

  // working registers
  logic [V_W-1:0]           v_r;
  logic [V_W-1:0]           i_r;
  logic signed [V_W:0]      dv;
  logic signed [V_W:0]      di;
  logic [NUM_W-1:0]         num_inc;
  logic [NUM_W-1:0]         num_inst;
  logic signed [DIFF_W-1:0] diff;
  logic signed [D_W-1:0]    d;
  logic                     peak;
  logic                     lowv_flag;

  // sequencer / divider hookup
  mppt_ic_pkg::op_t    op;
  mppt_ic_pkg::flags_t flags;
  logic [NUM_W-1:0]    q_inc;
  logic [NUM_W-1:0]    q_inst;
  logic                inc_busy;
  logic                inst_busy;
  logic                div_go;

  // combinational helpers
  logic [V_W:0]             dv_mag;
  logic [V_W:0]             di_mag;
  logic                     in_xfer;
  logic                     out_busy;
  logic                     emit;
  logic signed [DIFF_W-1:0] inc_term;
  logic signed [DIFF_W-1:0] inst_term;
  logic [DIFF_W-1:0]        diff_mag;
  logic signed [D_W-1:0]    duty_s;
  logic signed [D_W-1:0]    step_s;
  logic signed [D_W-1:0]    min_s;
  logic signed [D_W-1:0]    max_s;

  assign in_stall = (op != mppt_ic_pkg::OP_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;
  assign emit     = (op == mppt_ic_pkg::OP_EMIT) && !out_busy;
  assign div_go   = (op == mppt_ic_pkg::OP_DIVGO);

  assign dv_mag = dv[V_W] ? $unsigned(-dv) : $unsigned(dv);
  assign di_mag = di[V_W] ? $unsigned(-di) : $unsigned(di);

  assign flags.start    = in_valid;
  assign flags.low_v    = v_r < min_voltage_mv;
  assign flags.flat     = dv_mag < {{(V_W + 1 - TOL_W){1'b0}}, tolerance};
  assign flags.div_busy = inc_busy || inst_busy;
  assign flags.out_busy = out_busy;

  // inc is zero unless |dv| > 1; inst = -(i*1000/v) is zero when v is zero
  always_comb begin
    if (dv_mag > (V_W + 1)'(1)) begin
      inc_term = (di[V_W] ^ dv[V_W]) ? -$signed({2'b00, q_inc}) : $signed({2'b00, q_inc});
    end else begin
      inc_term = '0;
    end
    inst_term = (v_r != '0) ? $signed({2'b00, q_inst}) : '0;
  end

  assign diff_mag = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
  assign duty_s   = $signed({2'b00, duty_now});
  assign step_s   = $signed({2'b00, duty_step});
  assign min_s    = $signed({2'b00, duty_min});
  assign max_s    = $signed({2'b00, duty_max});

  mppt_ic_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  mppt_ic_div u_div_inc (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (num_inc),
    .divisor  (dv_mag[V_W-1:0]),
    .quotient (q_inc),
    .busy     (inc_busy)
  );

  mppt_ic_div u_div_inst (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (num_inst),
    .divisor  (v_r),
    .quotient (q_inst),
    .busy     (inst_busy)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_min       <= mppt_ic_pkg::RST_DUTY_MIN;
      duty_max       <= mppt_ic_pkg::RST_DUTY_MAX;
      duty_step      <= mppt_ic_pkg::RST_DUTY_STEP;
      tolerance      <= mppt_ic_pkg::RST_TOLERANCE;
      min_voltage_mv <= mppt_ic_pkg::RST_MIN_V;
      fallback_duty  <= mppt_ic_pkg::RST_FALLBACK;
    end else if (cfg_we) begin
      case (cfg_index)
        mppt_ic_pkg::CFG_DUTY_MIN:  duty_min       <= cfg_data[DUTY_W-1:0];
        mppt_ic_pkg::CFG_DUTY_MAX:  duty_max       <= cfg_data[DUTY_W-1:0];
        mppt_ic_pkg::CFG_DUTY_STEP: duty_step      <= cfg_data[DUTY_W-1:0];
        mppt_ic_pkg::CFG_TOLERANCE: tolerance      <= cfg_data[TOL_W-1:0];
        mppt_ic_pkg::CFG_MIN_V:     min_voltage_mv <= cfg_data[V_W-1:0];
        mppt_ic_pkg::CFG_FALLBACK:  fallback_duty  <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // tracker state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_now     <= mppt_ic_pkg::RST_DUTY_NOW;
      prev_voltage <= '0;
      prev_current <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        duty_now  <= d[DUTY_W-1:0];
        // low-voltage steps leave the stored sample alone
        if (!lowv_flag) begin
          prev_voltage <= v_r;
          prev_current <= i_r;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      duty        <= d[DUTY_W-1:0];
      at_peak     <= peak;
      low_voltage <= lowv_flag;
    end
  end

  // datapath, one micro-op per cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      v_r <= voltage_mv;
      i_r <= current_ma;
    end
    case (op)
      mppt_ic_pkg::OP_DIFF: begin
        dv       <= $signed({1'b0, v_r}) - $signed({1'b0, prev_voltage});
        di       <= $signed({1'b0, i_r}) - $signed({1'b0, prev_current});
        num_inst <= NUM_W'(i_r) * NUM_W'(mppt_ic_pkg::SCALE);
      end
      mppt_ic_pkg::OP_MUL: begin
        num_inc <= NUM_W'(di_mag[V_W-1:0]) * NUM_W'(mppt_ic_pkg::SCALE);
      end
      mppt_ic_pkg::OP_SUB: begin
        diff <= inc_term + inst_term;
      end
      mppt_ic_pkg::OP_DECIDE: begin
        lowv_flag <= 1'b0;
        if (diff_mag < DIFF_W'(tolerance)) begin
          peak <= 1'b1;
          d    <= duty_s;
        end else begin
          peak <= 1'b0;
          if (diff > 0) begin
            d <= duty_s - step_s;
          end else if (diff < 0) begin
            d <= duty_s + step_s;
          end else begin
            d <= duty_s;  // exact match with zero tolerance: hold, no flag
          end
        end
      end
      mppt_ic_pkg::OP_FLAT: begin
        lowv_flag <= 1'b0;
        peak      <= 1'b0;
        if (di_mag > (V_W + 1)'(tolerance)) begin
          d <= di[V_W] ? duty_s - step_s : duty_s + step_s;
        end else begin
          d <= duty_s;
        end
      end
      mppt_ic_pkg::OP_CLAMP: begin
        // crossed limits: below the lower limit goes up to it, else down to the upper
        if (d < min_s) begin
          d <= min_s;
        end else if (d > max_s) begin
          d <= max_s;
        end
      end
      mppt_ic_pkg::OP_FALLBK: begin
        lowv_flag <= 1'b1;
        peak      <= 1'b0;
        d         <= $signed({2'b00, fallback_duty});
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(op == mppt_ic_pkg::OP_EMIT))
    else $error("out_valid rose outside the emit step");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (op == mppt_ic_pkg::OP_SUB) |-> (!inc_busy && !inst_busy))
    else $error("quotients used while a divider is still busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(at_peak && low_voltage))
    else $error("at_peak and low_voltage both set");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("second sample taken right after a transfer");
`endif

endmodule

### sim/mppt_incremental_conductance_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_incremental_conductance_top_test
// Self-checking bench for the MPPT duty tracker: a directed opening for edge
// cases, then register settings from default to extreme, each fed with
// random panel samples shaped to hit the flat zone, near-peak and slope
// paths. A scoreboard class predicts each duty and checks results in order.
// ----------------------------------------------------------------------------
module mppt_incremental_conductance_top_test;

  localparam int V_W       = mppt_ic_pkg::V_W;
  localparam int DUTY_W    = mppt_ic_pkg::DUTY_W;
  localparam int CFG_IDX_W = mppt_ic_pkg::CFG_IDX_W;
  localparam int CFG_W     = mppt_ic_pkg::CFG_W;
  localparam int SCALE     = mppt_ic_pkg::SCALE;

  localparam int V_TOP     = 25000;   // random-sample ceiling in mV / mA
  localparam int LONG_HOLD = 300;     // receiver hold-off to back the block up
  localparam int DRAIN_PAD = 40;      // cycles after the last result

  // One result transfer as the block should present it.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              at_peak;
    logic              low_voltage;
  } duty_word_t;

  typedef enum int {SHAPE_NOISE, SHAPE_LOWV, SHAPE_FLAT, SHAPE_PEAK, SHAPE_SLOPE}
    sample_shape_t;

  // --------------------------------------------------------------------------
  // Duty predictor and checker. Mirrors the tracker's registers and state;
  // each accepted sample pushes the expected result word.
  // --------------------------------------------------------------------------
  class duty_tracker;
    int lo_duty, hi_duty, duty_step, tol, min_v, fallback;
    int duty_now, prev_v, prev_i;
    duty_word_t pending_duties[$];
    int n_fail, n_checked, n_low, n_flat, n_peak, n_up, n_down;

    function new();
      lo_duty   = mppt_ic_pkg::RST_DUTY_MIN;
      hi_duty   = mppt_ic_pkg::RST_DUTY_MAX;
      duty_step = mppt_ic_pkg::RST_DUTY_STEP;
      tol       = mppt_ic_pkg::RST_TOLERANCE;
      min_v     = mppt_ic_pkg::RST_MIN_V;
      fallback  = mppt_ic_pkg::RST_FALLBACK;
      duty_now  = mppt_ic_pkg::RST_DUTY_NOW;
      prev_v    = 0;
      prev_i    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int data);
      case (idx)
        mppt_ic_pkg::CFG_DUTY_MIN:  lo_duty   = data & 'hFF;
        mppt_ic_pkg::CFG_DUTY_MAX:  hi_duty   = data & 'hFF;
        mppt_ic_pkg::CFG_DUTY_STEP: duty_step = data & 'hFF;
        mppt_ic_pkg::CFG_TOLERANCE: tol       = data & 'h3FF;
        mppt_ic_pkg::CFG_MIN_V:     min_v     = data & 'h7FFF;
        mppt_ic_pkg::CFG_FALLBACK:  fallback  = data & 'hFF;
        default: ;
      endcase
    endfunction

    function longint magnitude(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function void note_sample(logic [V_W-1:0] v_in, logic [V_W-1:0] i_in);
      longint v, i, dv, di, d, inc, inst;
      duty_word_t w;
      v = v_in;
      i = i_in;
      d = duty_now;
      w = '0;
      if (v < min_v) begin
        // fallback: no clamp, previous sample left alone
        duty_now = fallback;
        w.duty = fallback[DUTY_W-1:0];
        w.low_voltage = 1'b1;
        n_low++;
      end else begin
        dv = v - prev_v;
        di = i - prev_i;
        if (magnitude(dv) < tol) begin
          n_flat++;
          if (magnitude(di) > tol) d += (di > 0) ? duty_step : -duty_step;
        end else begin
          inc  = 0;
          inst = 0;
          if (magnitude(dv) > 1) inc = (di * SCALE) / dv;
          if (v != 0) inst = -((i * SCALE) / v);
          if (magnitude(inc - inst) < tol) begin
            w.at_peak = 1'b1;
            n_peak++;
          end else if (inc > inst) begin
            d -= duty_step;
            n_down++;
          end else if (inc < inst) begin
            d += duty_step;
            n_up++;
          end
        end
        // crossed limits: the low bound wins for values below it
        if (d < lo_duty) d = lo_duty;
        else if (d > hi_duty) d = hi_duty;
        duty_now = int'(d) & 'h1FF;
        prev_v = v_in;
        prev_i = i_in;
        w.duty = d[DUTY_W-1:0];
      end
      pending_duties.push_back(w);
    endfunction

    function void check_result(logic [DUTY_W-1:0] duty, logic pk, logic lv);
      duty_word_t e;
      n_checked++;
      if (pending_duties.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("[%0t] unexpected result: duty %0d at_peak %0b low_voltage %0b",
                   $realtime, duty, pk, lv);
        return;
      end
      e = pending_duties.pop_front();
      if (e.duty !== duty || e.at_peak !== pk || e.low_voltage !== lv) begin
        n_fail++;
        if (n_fail <= 10)
          $display("[%0t] mismatch: duty exp %0d got %0d, at_peak exp %0b got %0b, %s%0b got %0b",
                   $realtime, e.duty, duty, e.at_peak, pk, "low_voltage exp ",
                   e.low_voltage, lv);
      end
    endfunction

    function int pending();
      return pending_duties.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and drive signals. Everything is driven on the falling edge and
  // sampled on the rising edge, so no check depends on event ordering.
  // --------------------------------------------------------------------------
  logic                 clk, rst;
  logic                 in_valid, in_stall;
  logic [V_W-1:0]       voltage_mv, current_ma;
  logic                 out_valid, out_stall;
  logic [DUTY_W-1:0]    duty;
  logic                 at_peak, low_voltage;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  duty_tracker sb = new();

  bit calm;          // set for the final stretch: no idling on either side
  int hold_asks;     // bumped by the sender to request one long receiver hold
  int n_settings;

  mppt_incremental_conductance_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .voltage_mv  (voltage_mv),
    .current_ma  (current_ma),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .duty        (duty),
    .at_peak     (at_peak),
    .low_voltage (low_voltage),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard ceiling on run time; the slowest legal run is far below this.
  initial begin
    #(5_000_000);
    $display("** mppt_incremental_conductance_top: FAILED **");
    $finish;
  end

  // Result side: every transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(duty, at_peak, low_voltage);
  end

  // Receiver back-pressure. Random stall bursts with open stretches
  // between; a long hold on request so the block fills up and pushes back
  // on its input. One assignment per falling edge.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  function automatic int clip(int x, int lo, int hi);
    return (x < lo) ? lo : (x > hi) ? hi : x;
  endfunction

  // All tasks below start and end on a falling edge.

  // Wait until every predicted result has been taken off the output.
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Offer one sample and hold it until the transfer happens, then maybe idle.
  // in_valid is never dropped and re-raised on the same edge.
  task automatic send_sample(input logic [V_W-1:0] v, input logic [V_W-1:0] i);
    in_valid   <= 1'b1;
    voltage_mv <= v;
    current_ma <= i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(v, i);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Register write; cfg_we stays high across back-to-back writes and the
  // caller drops it when the batch is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_W-1:0];
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Full register setting, only ever applied with the block idle.
  task automatic apply_setting(input int dmin, input int dmax, input int stp,
                               input int tl, input int mv, input int fb);
    in_valid <= 1'b0;
    @(negedge clk);
    drain();
    write_reg(mppt_ic_pkg::CFG_DUTY_MIN,  dmin);
    write_reg(mppt_ic_pkg::CFG_DUTY_MAX,  dmax);
    write_reg(mppt_ic_pkg::CFG_DUTY_STEP, stp);
    write_reg(mppt_ic_pkg::CFG_TOLERANCE, tl);
    write_reg(mppt_ic_pkg::CFG_MIN_V,     mv);
    write_reg(mppt_ic_pkg::CFG_FALLBACK,  fb);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Random sample, mostly built from the last stored sample so the tracker
  // sees plausible panel motion: tiny moves (flat zone), moves tuned so the
  // two conductances nearly match (at peak), broader slope moves, plus some
  // low-voltage drops and raw noise.
  task automatic make_sample(output logic [V_W-1:0] v, output logic [V_W-1:0] i);
    int last_v, last_i, tl, r, span, den, vi, ii, pick;
    sample_shape_t shape;
    last_v = sb.prev_v;
    last_i = sb.prev_i;
    tl     = sb.tol;
    pick   = $urandom_range(0, 99);
    shape  = (pick < 10) ? SHAPE_NOISE : (pick < 20) ? SHAPE_LOWV :
             (pick < 45) ? SHAPE_FLAT  : (pick < 75) ? SHAPE_PEAK : SHAPE_SLOPE;
    if (shape == SHAPE_LOWV && sb.min_v == 0) shape = SHAPE_NOISE;
    case (shape)
      SHAPE_LOWV: begin
        vi = $urandom_range(0, sb.min_v - 1);
        ii = $urandom_range(0, V_TOP);
      end
      SHAPE_FLAT: begin
        r  = (tl > 0) ? tl - 1 : 0;
        vi = clip(last_v + int'($urandom_range(0, 2 * r)) - r, 0, V_TOP);
        ii = clip(last_i + int'($urandom_range(0, 6 * tl + 10)) - (3 * tl + 5), 0, V_TOP);
      end
      SHAPE_PEAK: begin
        // di/dv = -i/v  =>  i = last_i * v / (2v - last_v)
        span = tl + $urandom_range(0, 400);
        vi   = clip(last_v + ($urandom_range(0, 1) ? span : -span), sb.min_v, V_TOP);
        den  = 2 * vi - last_v;
        ii   = (den > 0) ? last_i * vi / den : last_i;
        ii   = clip(ii + int'($urandom_range(0, 2 * tl + 2)) - (tl + 1), 0, V_TOP);
      end
      SHAPE_SLOPE: begin
        vi = clip(last_v + int'($urandom_range(0, 4000)) - 2000, 0, V_TOP);
        ii = clip(last_i + int'($urandom_range(0, 4000)) - 2000, 0, V_TOP);
      end
      default: begin
        vi = $urandom_range(0, V_TOP);
        ii = $urandom_range(0, V_TOP);
      end
    endcase
    v = vi[V_W-1:0];
    i = ii[V_W-1:0];
  endtask

  // One phase of random samples. Optionally asks for the long receiver hold
  // partway in, and later pauses the sender until the pipe is empty.
  task automatic run_random(input int n_items, input bit with_pressure);
    logic [V_W-1:0] v, i;
    for (int k = 0; k < n_items; k++) begin
      if (with_pressure && k == 40) hold_asks++;
      if (with_pressure && k == 120) begin
        in_valid <= 1'b0;
        @(negedge clk);
        drain();
      end
      make_sample(v, i);
      send_sample(v, i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int dir_v[$];
    int dir_i[$];
    rst        = 1'b1;
    in_valid   = 1'b0;
    voltage_mv = '0;
    current_ma = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    hold_asks  = 0;
    n_settings = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening at reset registers (duty 80, previous sample zero):
    // zero input, just below / at the voltage floor, full-scale fields,
    // flat zone at and past the current dead band, dv exactly at tolerance,
    // a match at peak, lower and raise moves, and fallback keeping the
    // previous sample.
    dir_v = '{0, 999, 1000, 25000, 25000, 25000, 25005, 25005, 25015,
              10000, 10100, 10000, 10100, 10000, 10100, 10000, 999, 10100};
    dir_i = '{0, 500, 0, 25000, 0, 0, 10, 21, 21,
              5000, 1000, 5000, 1000, 5000, 1000, 5000, 32767, 1000};
    foreach (dir_v[k]) send_sample(dir_v[k], dir_i[k]);

    // Zero voltage with a zero floor, and exact equality at zero tolerance:
    // both conductances come out zero, so duty holds without a peak flag.
    apply_setting(10, 150, 5, 0, 0, 20);
    send_sample(0, 0);
    send_sample(0, 5);
    // One-millivolt change at tolerance one: incremental term forced to zero.
    apply_setting(10, 150, 5, 1, 0, 20);
    send_sample(5000, 100);
    send_sample(5001, 200);
    // Crossed limits: below the low bound goes up to it, else down to high.
    apply_setting(200, 100, 5, 10, 1000, 20);
    send_sample(5000, 100);
    send_sample(5200, 100);
    send_sample(5000, 4000);

    // Random phases over a spread of register settings.
    apply_setting(mppt_ic_pkg::RST_DUTY_MIN, mppt_ic_pkg::RST_DUTY_MAX,
                  mppt_ic_pkg::RST_DUTY_STEP, mppt_ic_pkg::RST_TOLERANCE,
                  mppt_ic_pkg::RST_MIN_V, mppt_ic_pkg::RST_FALLBACK);
    run_random(200, 1'b1);
    apply_setting(0, 255, 1, 0, 0, 0);
    run_random(150, 1'b0);
    apply_setting(0, 255, 255, 1000, V_TOP, 255);
    run_random(60, 1'b0);
    apply_setting(200, 100, 7, 3, 500, 90);
    run_random(120, 1'b0);
    for (int p = 0; p < 3; p++) begin
      apply_setting($urandom_range(0, 120), $urandom_range(80, 255),
                    $urandom_range(0, 30),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000)
                                                : $urandom_range(0, 40),
                    $urandom_range(0, 6000), $urandom_range(0, 255));
      if (p == 2) calm = 1'b1;
      run_random(120, 1'b0);
    end

    in_valid <= 1'b0;
    drain();
    repeat (DRAIN_PAD) @(negedge clk);

    $display("Run covered %0d samples under %0d register settings:", sb.n_checked,
             n_settings);
    $display("  %0d low-voltage, %0d flat-zone, %0d at peak, %0d raised, %0d lowered",
             sb.n_low, sb.n_flat, sb.n_peak, sb.n_up, sb.n_down);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("** mppt_incremental_conductance_top: PASSED **");
    end else begin
      $display("%0d failures, %0d results never seen", sb.n_fail, sb.pending());
      $display("** mppt_incremental_conductance_top: FAILED **");
    end
    $finish;
  end

endmodule
